[hw/rtl/bra_pkg.sv]
package bra_pkg;

  localparam int unsigned MapBits  = 32768;
  localparam int unsigned MaxRun   = 1024;
  localparam int unsigned WordBits = 32;

  localparam int unsigned TypeW   = 2;
  localparam int unsigned IndexW  = 15;
  localparam int unsigned LenW    = 11;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgW-1:0] UsableReset = 16'd32768;

  // request codes
  localparam logic [TypeW-1:0] ReqAlloc   = 2'd0;
  localparam logic [TypeW-1:0] ReqFree    = 2'd1;
  localparam logic [TypeW-1:0] ReqReserve = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StNoSpace = 2'd1;
  localparam logic [StatusW-1:0] StRange   = 2'd2;

  typedef struct packed {
    logic [TypeW-1:0]  req_type;
    logic [IndexW-1:0] bit_index;
    logic [LenW-1:0]   run_length;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IndexW-1:0]  start_index;
    logic               previous_bit;
  } rsp_t;

endpackage

[hw/rtl/bra_req_if.sv]
interface bra_req_if;
  import bra_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/bra_rsp_if.sv]
interface bra_rsp_if;
  import bra_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/bra_ram.sv]
module bra_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

[hw/rtl/bitmap_run_allocator_core.sv]
// bitmap run allocator: first-fit free-block map, one bit per block (1 = used)
//
// channels: req_i carries requests (type, bit index, run length); rsp_o
// carries one response per request (status, start index, previous bit).
// usable_bits is set through cfg_we_i / cfg_wdata_i; the user must do so only
// while the block is idle (the block itself does not enforce this).
// one request at a time. the map sits in a RAM of MapBits/WordBits words with
// registered read; the shared bit-scan unit handles one bit per cycle, but
// pauses to fetch each word (SRead, SWait; when marking SMarkRd, SMarkWt and
// the write-back in SMarkWr). a rejected request goes straight to the
// response; reserve reads, sets and writes back one word; free clears its run
// word by word; allocate first scans from bit 0 for a free run, then sets it
// word by word; the scan covers at most the whole map.
// req_i is ready only while idle. after reset a clearing pass writes zero to
// every map word with req_i not ready; usable_bits resets to 32768. a
// finished response waits in an output register until rsp_o is taken, and
// req_i is ready again in the cycle after that.
module bitmap_run_allocator_core #(
  parameter int unsigned MAP_BITS  = bra_pkg::MapBits,
  parameter int unsigned MAX_RUN   = bra_pkg::MaxRun,
  parameter int unsigned WORD_BITS = bra_pkg::WordBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bra_pkg::CfgW-1:0] cfg_wdata_i,
  bra_req_if.sink                  req_i,
  bra_rsp_if.source                rsp_o
);
  import bra_pkg::*;

  localparam int unsigned Words = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned BW    = $clog2(WORD_BITS);
  localparam int unsigned PW    = $clog2(MAP_BITS + 1) + 1;
  localparam int unsigned CW    = $clog2(MAX_RUN + 1);

  localparam logic [3:0] SClear = 4'd0, SIdle = 4'd1, SRead = 4'd2, SWait = 4'd3,
                         SScan = 4'd4, SMark = 4'd5, SMarkRd = 4'd6, SMarkWt = 4'd7,
                         SMarkWr = 4'd8, SResp = 4'd9;

  logic [3:0] state_q, state_d;
  logic [CfgW-1:0] usable_q;
  logic [PW-1:0] lim;
  logic [TypeW-1:0] type_q;
  logic [PW-1:0] pos_q, pos_d;        // current bit position
  logic [PW-1:0] end_q, end_d;        // exclusive end of marked range
  logic [PW-1:0] start_q, start_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] len_q;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [AW-1:0] clr_q, clr_d;
  rsp_t rsp_q, rsp_d;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  function automatic logic len_in_ok(input logic [LenW-1:0] l);
    len_in_ok = (l != '0) && ({{(32-LenW){1'b0}}, l} <= 32'(MAX_RUN));
  endfunction

  // effective bound
  always_comb begin
    if ({{(PW > CfgW ? PW-CfgW : 0){1'b0}}, usable_q} > PW'(MAP_BITS)) lim = PW'(MAP_BITS);
    else lim = PW'(usable_q);
  end

  bra_ram #(.Width(WORD_BITS), .Depth(Words)) u_map (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [PW-1:0] in_idx, in_end;
  assign in_idx = PW'(req_i.payload.bit_index);
  assign in_end = in_idx + PW'(req_i.payload.run_length);

  // scan/mark unit: one bit of the held word per step, word ram access shared
  logic [BW-1:0] boff;
  logic cur_bit;
  assign boff    = pos_q[BW-1:0];
  assign cur_bit = word_q[boff];
  assign raddr   = AW'(pos_q >> BW);

  always_comb begin
    state_d = state_q; pos_d = pos_q; end_d = end_q; start_d = start_q;
    cnt_d = cnt_q; word_d = word_q; clr_d = clr_q; rsp_d = rsp_q;
    we = 1'b0; waddr = AW'(pos_q >> BW); wdata = word_q;
    unique case (state_q)
      SClear: begin
        we = 1'b1; waddr = clr_q; wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(Words - 1)) state_d = SIdle;
      end
      SIdle: begin
        // request intake: range checks decide between work and an early response
        if (req_i.valid) begin
          cnt_d   = '0;
          rsp_d   = '{status: StRange, start_index: '0, previous_bit: 1'b0};
          state_d = SResp;
          if (req_i.payload.req_type == ReqAlloc) begin
            pos_d = '0;
          end else begin
            pos_d = in_idx;
            end_d = (req_i.payload.req_type == ReqReserve) ? in_idx + 1'b1 : in_end;
          end
          unique case (req_i.payload.req_type)
            ReqAlloc: if (len_in_ok(req_i.payload.run_length)) state_d = SRead;
            ReqFree:  if (len_in_ok(req_i.payload.run_length) && in_end <= lim)
                        state_d = SMarkRd;
            ReqReserve: if (in_idx < lim) state_d = SMarkRd;
            default: ;
          endcase
        end
      end
      SRead: state_d = SWait;
      SWait: begin
        word_d = rdata;
        state_d = (type_q == ReqAlloc) ? SScan : SMark;
      end
      SScan: begin
        // one bit per cycle against the run counter; a word end goes back to SRead
        if (pos_q >= lim) begin
          rsp_d = '{status: StNoSpace, start_index: '0, previous_bit: 1'b0};
          state_d = SResp;
        end else if (!cur_bit && (PW'(cnt_q) + 1'b1 >= PW'(len_q))) begin
          start_d = pos_q + 1'b1 - PW'(len_q);
          pos_d = pos_q + 1'b1 - PW'(len_q);
          end_d = pos_q + 1'b1;
          state_d = SMarkRd;
        end else begin
          cnt_d = cur_bit ? '0 : cnt_q + 1'b1;
          pos_d = pos_q + 1'b1;
          if (boff == BW'(WORD_BITS - 1)) state_d = SRead;
        end
      end
      SMarkRd: state_d = SMarkWt;
      SMarkWt: begin word_d = rdata; state_d = SMark; end
      SMark: begin
        // set/clear one bit per cycle; write back at word end or range end
        if (type_q == ReqReserve) begin
          rsp_d = '{status: StOk, start_index: '0, previous_bit: cur_bit};
          word_d[boff] = 1'b1;
          state_d = SMarkWr;
        end else begin
          word_d[boff] = (type_q == ReqAlloc);
          pos_d = pos_q + 1'b1;
          if (pos_q + 1'b1 == end_q || boff == BW'(WORD_BITS - 1)) state_d = SMarkWr;
        end
      end
      SMarkWr: begin
        we = 1'b1;
        waddr = (type_q == ReqReserve) ? AW'(pos_q >> BW) : AW'((pos_q - 1'b1) >> BW);
        if (type_q == ReqReserve || pos_q == end_q) begin
          if (type_q == ReqAlloc)
            rsp_d = '{status: StOk, start_index: IndexW'(start_q), previous_bit: 1'b0};
          else if (type_q == ReqFree)
            rsp_d = '{status: StOk, start_index: '0, previous_bit: 1'b0};
          state_d = SResp;
        end else state_d = SMarkRd;
      end
      SResp: if (rsp_o.ready) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  assign req_i.ready     = (state_q == SIdle);
  assign rsp_o.valid     = (state_q == SResp);
  assign rsp_o.payload   = rsp_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SClear;
      clr_q    <= '0;
      usable_q <= UsableReset;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) usable_q <= cfg_wdata_i;
    end
  end

  // datapath registers, request fields held while the request is worked on
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; end_q <= end_d; start_q <= start_d;
    cnt_q <= cnt_d; word_q <= word_d; rsp_q <= rsp_d;
    if (req_i.valid && state_q == SIdle) begin
      type_q <= req_i.payload.req_type;
      len_q  <= req_i.payload.run_length;
    end
  end

endmodule

[sim/testbench.sv]
module testbench;
  import bra_pkg::*;

  localparam int unsigned MapWords  = MapBits / WordBits;
  localparam int unsigned StallLimit = 200000;
  localparam int unsigned ItemTarget = 540;

  // keeps its own copy of the block map and the expected responses
  class alloc_scoreboard;
    logic [WordBits-1:0] usage[MapWords];
    logic [CfgW-1:0]     usable;
    rsp_t                awaited[$];
    int unsigned         mismatches;

    function new();
      foreach (usage[w]) usage[w] = '0;
      usable     = UsableReset;
      mismatches = 0;
    endfunction

    function bit used(int unsigned i);
      return usage[i / WordBits][i % WordBits];
    endfunction

    function void mark(int unsigned i, bit v);
      usage[i / WordBits][i % WordBits] = v;
    endfunction

    // work out the response to one accepted request and update the map
    function void note_request(req_t r);
      int unsigned lim;
      int unsigned run;
      int unsigned idx;
      int unsigned len;
      bit          found;
      rsp_t        e;
      lim = (usable > MapBits) ? MapBits : usable;
      idx = r.bit_index;
      len = r.run_length;
      e.status       = StRange;
      e.start_index  = '0;
      e.previous_bit = 1'b0;
      found = 1'b0;
      case (r.req_type)
        ReqAlloc: begin
          if (len >= 1 && len <= MaxRun) begin
            run = 0;
            for (int unsigned i = 0; i < lim; i++) begin
              run = used(i) ? 0 : run + 1;
              if (run >= len) begin
                e.start_index = IndexW'(i + 1 - len);
                found = 1'b1;
                break;
              end
            end
            if (found) begin
              for (int unsigned i = e.start_index; i < e.start_index + len; i++) mark(i, 1'b1);
              e.status = StOk;
            end else begin
              e.status = StNoSpace;
            end
          end
        end
        ReqFree: begin
          if (len >= 1 && len <= MaxRun && idx + len <= lim) begin
            for (int unsigned i = idx; i < idx + len; i++) mark(i, 1'b0);
            e.status = StOk;
          end
        end
        ReqReserve: begin
          if (idx < lim) begin
            e.previous_bit = used(idx);
            mark(idx, 1'b1);
            e.status = StOk;
          end
        end
        default: ;
      endcase
      awaited.push_back(e);
    endfunction

    // compare one response with the oldest expectation
    function void check_response(rsp_t got);
      rsp_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      e = awaited.pop_front();
      if (got.status !== e.status || got.start_index !== e.start_index ||
          got.previous_bit !== e.previous_bit) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response mismatch: expected %p, got %p", e, got);
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  bra_req_if req_bus ();
  bra_rsp_if rsp_bus ();

  bitmap_run_allocator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  alloc_scoreboard sb = new();

  int unsigned burst_left;
  int unsigned hold_left;
  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned idle_cycles;
  int unsigned items_sent;

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // monitors on both channels
  always @(posedge clk_i) begin
    if (rst_ni && req_bus.valid && req_bus.ready) sb.note_request(req_bus.payload);
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) sb.check_response(rsp_bus.payload);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // response stall pattern, with a long hold-off when asked for
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 300);
      end else begin
        mode_left = mode_left - 1;
      end
      case (stall_mode)
        0: rsp_bus.ready <= 1'b1;
        1: rsp_bus.ready <= ($urandom_range(0, 1) == 0);
        default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // offer one request, in bursts with random gaps
  task automatic send_request(req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left = burst_left - 1;
    req_bus.valid   <= 1'b1;
    req_bus.payload <= r;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_fields(logic [TypeW-1:0] t, int unsigned idx, int unsigned len);
    req_t r;
    r.req_type   = t;
    r.bit_index  = IndexW'(idx);
    r.run_length = LenW'(len);
    send_request(r);
  endtask

  // let all responses drain, then settle
  task automatic drain();
    req_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.awaited.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_usable(logic [CfgW-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    sb.usable = v;
  endtask

  // random request shaped by the current bound
  function automatic req_t random_request(int unsigned lim);
    req_t        r;
    int unsigned pick;
    r.req_type   = TypeW'($urandom());
    r.bit_index  = IndexW'($urandom());
    r.run_length = LenW'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 10) return r;
    if (pick < 50) begin
      r.req_type = ReqAlloc;
      case ($urandom_range(0, 9))
        0:       r.run_length = LenW'($urandom_range(65, MaxRun));
        1, 2:    r.run_length = LenW'($urandom_range(9, 64));
        default: r.run_length = LenW'($urandom_range(1, 8));
      endcase
    end else if (pick < 78) begin
      r.req_type   = ReqFree;
      r.run_length = LenW'($urandom_range(1, 16));
      if (lim > 0) r.bit_index = IndexW'($urandom_range(0, lim - 1));
    end else begin
      r.req_type = ReqReserve;
      if ($urandom_range(0, 4) != 0)
        r.bit_index = IndexW'($urandom_range(0, (lim > 0) ? lim : 0));
    end
    return r;
  endfunction

  task automatic random_phase(logic [CfgW-1:0] v, int unsigned n, bit long_hold);
    int unsigned lim;
    write_usable(v);
    lim = (v > MapBits) ? MapBits : v;
    if (long_hold) hold_left = 400;
    repeat (n) send_request(random_request(lim));
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    req_bus.valid   = 1'b0;
    req_bus.payload = '0;
    rsp_bus.ready   = 1'b0;
    burst_left  = 0;
    hold_left   = 0;
    stall_mode  = 0;
    mode_left   = 0;
    idle_cycles = 0;
    items_sent  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed requests at the reset bound
    send_fields(ReqAlloc, 0, 1);
    send_fields(ReqAlloc, 32767, MaxRun);
    send_fields(ReqAlloc, 0, 0);
    send_fields(ReqAlloc, 0, MaxRun + 1);
    send_fields(ReqAlloc, 0, 2047);
    send_fields(ReqReserve, 0, 0);
    send_fields(ReqReserve, 2000, 2047);
    send_fields(ReqReserve, 2000, 5);
    send_fields(ReqReserve, 32767, 0);
    send_fields(ReqFree, 32767, 1);
    send_fields(ReqFree, 32767, 2);
    send_fields(ReqFree, 1, MaxRun);
    send_fields(ReqFree, 5, 0);
    send_fields(ReqFree, 5000, 3);
    send_fields(ReqFree, 100, 2047);
    send_fields(TypeW'(3), 32767, 2047);
    send_fields(ReqAlloc, 0, 5);
    send_fields(ReqAlloc, 0, MaxRun);

    // empty bound, then out-of-range register value
    write_usable(16'd0);
    send_fields(ReqAlloc, 0, 1);
    send_fields(ReqReserve, 0, 0);
    send_fields(ReqFree, 0, 1);
    write_usable(16'hFFFF);
    send_fields(ReqReserve, 32767, 0);
    send_fields(ReqAlloc, 0, 3);

    random_phase(16'd64, 90, 1'b1);
    random_phase(16'd1, 30, 1'b0);
    random_phase(16'd300, 90, 1'b0);
    random_phase(16'd0, 15, 1'b0);
    random_phase(16'd2000, 90, 1'b1);
    random_phase(16'd100, 90, 1'b0);
    random_phase(16'hFFFF, 50, 1'b0);
    random_phase(16'd32768, ItemTarget - items_sent, 1'b0);

    // finish: all responses back, then settle
    drain();
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
